// ===== src/assert_macros.svh =====
// Assertion macros for the port-level checker.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never holds while reset is released.
`define CHK_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== src/vptg_pkg.sv =====
// Package for the video playout timing gate: beat types, codes and widths.
// Used by the divider, the top level and the checker; depends on nothing.
package vptg_pkg;

    localparam int STREAK_LIMIT = 6;
    localparam int CNT_W        = $clog2(STREAK_LIMIT + 2);

    localparam int PTS_W    = 32;
    localparam int TICK_W   = 32;
    localparam int RATE_W   = 20;
    localparam int MS_W     = 14;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    localparam int MS_PER_SEC = 1000;
    localparam int MUL_W      = 10;
    localparam int DIVD_W     = PTS_W + MUL_W;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int REL_W      = DIVD_W + 1;
    localparam int LEAD_W     = REL_W + 3;

    localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(90000);
    localparam logic [MS_W-1:0]   CACHE_RESET = MS_W'(100);
    localparam logic [MS_W-1:0]   LEAD_RESET  = MS_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_TO_MS   = 2'd0,
        CFG_CLOCK_RATE    = 2'd1,
        CFG_CACHE_TIME_MS = 2'd2,
        CFG_MAX_LEAD_MS   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        VERDICT_PLAY = 2'd0,
        VERDICT_LATE = 2'd1,
        VERDICT_WAIT = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_LEAD,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              action;
        logic [PTS_W-1:0]  frame_pts;
        logic [TICK_W-1:0] now_ms;
        logic              is_keyframe;
    } in_beat_t;

    typedef struct packed {
        verdict_t           verdict;
        logic               flush_cache;
        logic               rebased;
        logic signed [31:0] lead_ms;
    } out_beat_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [RATE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/video_playout_timing_gate_unit.sv =====
// Top level of the video playout timing gate: sequencer, clock state and result register.
// With scaling a frame runs through PREP, MUL, DIVGO, DIV, LEAD, DECIDE and EMIT; without
// it skips DIVGO and DIV, and a first frame goes from PREP to EMIT. Scaled frames use the one-bit-per-cycle divider.
// One frame is handled at a time; a reset beat clears the clock state and gives no result.
// A new beat is taken only in IDLE, after the last frame has left EMIT, and while its result waits.
// Reset is synchronous on aresetn low and loads the register defaults and clears all clock state.
module video_playout_timing_gate_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [vptg_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [vptg_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vptg_pkg::in_beat_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output vptg_pkg::out_beat_t               m_data
);

    vptg_pkg::state_t state_reg, state_next;

    logic                        scale_reg;
    logic [vptg_pkg::RATE_W-1:0] rate_reg;
    logic [vptg_pkg::MS_W-1:0]   cache_reg;
    logic [vptg_pkg::MS_W-1:0]   max_lead_reg;

    logic [vptg_pkg::PTS_W-1:0]  base_pts_reg;
    logic [vptg_pkg::TICK_W-1:0] start_tick_reg;
    logic                        first_seen_reg;
    logic                        kf_synced_reg;
    logic                        base_valid_reg;
    logic [vptg_pkg::CNT_W-1:0]  late_cnt_reg;
    logic [vptg_pkg::CNT_W-1:0]  early_cnt_reg;

    logic [vptg_pkg::PTS_W-1:0]  pts_reg;
    logic [vptg_pkg::TICK_W-1:0] now_reg;
    logic                        key_reg;
    logic                        neg_reg;
    logic [vptg_pkg::PTS_W-1:0]  mag_reg;
    logic [vptg_pkg::TICK_W-1:0] elapsed_reg;
    logic [vptg_pkg::DIVD_W-1:0] prod_reg;
    logic [vptg_pkg::DIVD_W-1:0] rel_mag_reg;
    logic signed [vptg_pkg::LEAD_W-1:0] lead_reg;
    logic                        rebased_reg;
    vptg_pkg::out_beat_t         res_reg;
    logic                        m_valid_reg;
    vptg_pkg::out_beat_t         m_data_reg;

    logic                        accept;
    logic                        first_frame;
    logic                        prep_load;
    logic [vptg_pkg::PTS_W-1:0]  base_eff;
    logic [vptg_pkg::TICK_W-1:0] start_eff;
    logic [vptg_pkg::PTS_W:0]    delta;
    logic signed [vptg_pkg::REL_W-1:0]  rel;
    logic signed [vptg_pkg::LEAD_W-1:0] lead_calc;
    logic                        is_late;
    logic                        is_play;
    logic                        late_roll;
    logic                        early_roll;
    logic                        dec_rebase;
    logic signed [31:0]          lead_sat;
    logic                        out_free;
    logic                        div_start;
    vptg_pkg::div_req_t          div_req;
    vptg_pkg::div_rsp_t          div_rsp;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vptg_pkg::ST_IDLE: begin
                if (accept && !s_data.action) begin
                    state_next = vptg_pkg::ST_PREP;
                end
            end
            vptg_pkg::ST_PREP: begin
                state_next = first_frame ? vptg_pkg::ST_EMIT : vptg_pkg::ST_MUL;
            end
            vptg_pkg::ST_MUL: begin
                state_next = scale_reg ? vptg_pkg::ST_DIVGO : vptg_pkg::ST_LEAD;
            end
            vptg_pkg::ST_DIVGO: begin
                state_next = vptg_pkg::ST_DIV;
            end
            vptg_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = vptg_pkg::ST_LEAD;
                end
            end
            vptg_pkg::ST_LEAD: begin
                state_next = vptg_pkg::ST_DECIDE;
            end
            vptg_pkg::ST_DECIDE: begin
                state_next = vptg_pkg::ST_EMIT;
            end
            vptg_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = vptg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vptg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            vptg_pkg::ST_IDLE:  s_ready   = 1'b1;
            vptg_pkg::ST_DIVGO: div_start = 1'b1;
            default: begin
                s_ready   = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        first_frame = !base_valid_reg && !first_seen_reg;
        prep_load   = !base_valid_reg || (!kf_synced_reg && key_reg);
        base_eff    = prep_load ? pts_reg : base_pts_reg;
        start_eff   = prep_load ? now_reg : start_tick_reg;
        delta       = {1'b0, pts_reg} - {1'b0, base_eff};
    end

    always_comb begin
        rel = neg_reg ? -$signed({1'b0, rel_mag_reg}) : $signed({1'b0, rel_mag_reg});
        lead_calc = vptg_pkg::LEAD_W'(rel)
                  + $signed({{(vptg_pkg::LEAD_W - vptg_pkg::MS_W){1'b0}}, cache_reg})
                  - $signed({{(vptg_pkg::LEAD_W - vptg_pkg::TICK_W){1'b0}}, elapsed_reg});
    end

    always_comb begin
        is_late    = lead_reg[vptg_pkg::LEAD_W-1];
        is_play    = !is_late && (lead_reg <= $signed({{(vptg_pkg::LEAD_W - vptg_pkg::MS_W){1'b0}},
                                                      max_lead_reg}));
        late_roll  = is_late && (late_cnt_reg == vptg_pkg::CNT_W'(vptg_pkg::STREAK_LIMIT));
        early_roll = !is_late && !is_play
                     && (early_cnt_reg == vptg_pkg::CNT_W'(vptg_pkg::STREAK_LIMIT));
        dec_rebase = late_roll || early_roll || (is_play && key_reg);
        if (lead_reg > $signed(vptg_pkg::LEAD_W'(32'sh7FFF_FFFF))) begin
            lead_sat = 32'sh7FFF_FFFF;
        end else if (lead_reg < -$signed(vptg_pkg::LEAD_W'(33'sh0_8000_0000))) begin
            lead_sat = 32'sh8000_0000;
        end else begin
            lead_sat = lead_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vptg_pkg::ST_IDLE;
            scale_reg    <= 1'b1;
            rate_reg     <= vptg_pkg::RATE_RESET;
            cache_reg    <= vptg_pkg::CACHE_RESET;
            max_lead_reg <= vptg_pkg::LEAD_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (vptg_pkg::cfg_idx_t'(cfg_addr))
                    vptg_pkg::CFG_SCALE_TO_MS:   scale_reg    <= cfg_wdata[0];
                    vptg_pkg::CFG_CLOCK_RATE:    rate_reg     <= cfg_wdata[vptg_pkg::RATE_W-1:0];
                    vptg_pkg::CFG_CACHE_TIME_MS: cache_reg    <= cfg_wdata[vptg_pkg::MS_W-1:0];
                    vptg_pkg::CFG_MAX_LEAD_MS:   max_lead_reg <= cfg_wdata[vptg_pkg::MS_W-1:0];
                    default: begin
                        scale_reg <= scale_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_data.action)) begin
            base_pts_reg   <= '0;
            start_tick_reg <= '0;
            first_seen_reg <= 1'b0;
            kf_synced_reg  <= 1'b0;
            base_valid_reg <= 1'b0;
            late_cnt_reg   <= '0;
            early_cnt_reg  <= '0;
        end else if (state_reg == vptg_pkg::ST_PREP) begin
            if (first_frame) begin
                first_seen_reg <= 1'b1;
            end else begin
                base_pts_reg   <= base_eff;
                start_tick_reg <= start_eff;
                base_valid_reg <= 1'b1;
                if (key_reg) begin
                    kf_synced_reg <= 1'b1;
                end
            end
        end else if (state_reg == vptg_pkg::ST_DECIDE) begin
            if (dec_rebase) begin
                base_pts_reg   <= pts_reg;
                start_tick_reg <= now_reg;
            end
            if (is_late) begin
                late_cnt_reg <= late_roll ? '0 : late_cnt_reg + 1'b1;
            end else if (!is_play) begin
                early_cnt_reg <= early_roll ? '0 : early_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pts_reg <= s_data.frame_pts;
            now_reg <= s_data.now_ms;
            key_reg <= s_data.is_keyframe;
        end
        if (state_reg == vptg_pkg::ST_PREP) begin
            neg_reg     <= delta[vptg_pkg::PTS_W];
            mag_reg     <= delta[vptg_pkg::PTS_W] ? vptg_pkg::PTS_W'(-delta)
                                                 : delta[vptg_pkg::PTS_W-1:0];
            elapsed_reg <= now_reg - start_eff;
            rebased_reg <= prep_load;
            res_reg.verdict     <= vptg_pkg::VERDICT_PLAY;
            res_reg.flush_cache <= 1'b1;
            res_reg.rebased     <= 1'b0;
            res_reg.lead_ms     <= '0;
        end
        if (state_reg == vptg_pkg::ST_MUL) begin
            prod_reg    <= {{vptg_pkg::MUL_W{1'b0}}, mag_reg}
                           * vptg_pkg::DIVD_W'(vptg_pkg::MS_PER_SEC);
            rel_mag_reg <= {{vptg_pkg::MUL_W{1'b0}}, mag_reg};
        end
        if ((state_reg == vptg_pkg::ST_DIV) && div_rsp.done) begin
            rel_mag_reg <= div_rsp.quotient;
        end
        if (state_reg == vptg_pkg::ST_LEAD) begin
            lead_reg <= lead_calc;
        end
        if (state_reg == vptg_pkg::ST_DECIDE) begin
            res_reg.verdict     <= is_late ? vptg_pkg::VERDICT_LATE
                                 : (is_play ? vptg_pkg::VERDICT_PLAY : vptg_pkg::VERDICT_WAIT);
            res_reg.flush_cache <= 1'b0;
            res_reg.rebased     <= rebased_reg || dec_rebase;
            res_reg.lead_ms     <= lead_sat;
        end
        if ((state_reg == vptg_pkg::ST_EMIT) && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == vptg_pkg::ST_EMIT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = (rate_reg == '0) ? vptg_pkg::RATE_W'(1) : rate_reg;

    vptg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/vptg_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on vptg_pkg for widths and the request and response types.
module vptg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  vptg_pkg::div_req_t req,
    output vptg_pkg::div_rsp_t rsp
);

    logic [vptg_pkg::RATE_W-1:0]    rem_reg, rem_next;
    logic [vptg_pkg::DIVD_W-1:0]    quo_reg, quo_next;
    logic [vptg_pkg::RATE_W-1:0]    dsr_reg;
    logic [vptg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [vptg_pkg::RATE_W:0]      shifted;
    logic [vptg_pkg::RATE_W:0]      diff;
    logic                           ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[vptg_pkg::DIVD_W-1]};
        ge      = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = vptg_pkg::DIV_CNT_W'(vptg_pkg::DIVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[vptg_pkg::RATE_W-1:0] : shifted[vptg_pkg::RATE_W-1:0];
            quo_next = {quo_reg[vptg_pkg::DIVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == vptg_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start) begin
            dsr_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/vptg_checker.sv =====
// Port-level checker for the video playout timing gate, bound to the top level.
// Depends on vptg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vptg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input vptg_pkg::in_beat_t             s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input vptg_pkg::out_beat_t            m_data
);

    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat changed while stalled")
    `CHK_ASSERT(a_verdict_code, aclk, aresetn, m_valid |-> (m_data.verdict == vptg_pkg::VERDICT_PLAY || m_data.verdict == vptg_pkg::VERDICT_LATE || m_data.verdict == vptg_pkg::VERDICT_WAIT), "undefined verdict code")
    `CHK_ASSERT(a_flush_shape, aclk, aresetn, m_valid && m_data.flush_cache |-> m_data.verdict == vptg_pkg::VERDICT_PLAY && !m_data.rebased && m_data.lead_ms == 32'sd0, "first-frame result malformed")
    `CHK_ASSERT(a_late_sign, aclk, aresetn, m_valid |-> ((m_data.verdict == vptg_pkg::VERDICT_LATE) == m_data.lead_ms[31]), "verdict disagrees with lead sign")
    `CHK_ASSERT(a_reset_beat, aclk, aresetn, s_valid && s_ready && s_data.action |=> s_ready, "reset beat did not return to idle")

endmodule

bind video_playout_timing_gate_unit vptg_checker u_vptg_checker (.*);

// ===== bench/playout_verdict_checker.sv =====
// Checker for the video playout timing gate: watches the register port and both channels,
// predicts each frame's verdict and compares it with the result beats in order.
// Depends on vptg_pkg for the beat types, register indexes and reset values.
module playout_verdict_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [vptg_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [vptg_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  vptg_pkg::in_beat_t             s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  vptg_pkg::out_beat_t            m_data,
    input  logic                           end_of_run,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                          scale_on;
    logic [vptg_pkg::RATE_W-1:0]   rate_reg;
    logic [vptg_pkg::MS_W-1:0]     cache_reg;
    logic [vptg_pkg::MS_W-1:0]     lead_cap;

    logic [vptg_pkg::PTS_W-1:0]    base_pts_q;
    logic [vptg_pkg::TICK_W-1:0]   start_tick_q;
    logic                          seen_first;
    logic                          key_synced;
    logic                          base_loaded;
    int                            late_run;
    int                            early_run;

    vptg_pkg::out_beat_t           verdict_q[$];
    int                            fail_tally = 0;
    bit                            ended = 0;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what);
        fail_tally++;
        if (fail_tally <= 100) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic clear_clock_state();
        base_pts_q = '0;
        start_tick_q = '0;
        seen_first = 1'b0;
        key_synced = 1'b0;
        base_loaded = 1'b0;
        late_run = 0;
        early_run = 0;
    endtask

    task automatic load_base(input logic [vptg_pkg::PTS_W-1:0] pts,
                             input logic [vptg_pkg::TICK_W-1:0] now);
        base_pts_q = pts;
        start_tick_q = now;
        base_loaded = 1'b1;
    endtask

    task automatic judge_frame(input vptg_pkg::in_beat_t b);
        vptg_pkg::out_beat_t         r;
        logic                        rb;
        longint                      pts_l;
        longint                      base_l;
        longint                      delta;
        longint                      rel;
        longint                      lead;
        longint                      divisor;
        longint                      elapsed_l;
        longint                      cache_l;
        longint                      cap_l;
        logic [vptg_pkg::TICK_W-1:0] elapsed;
        r = '0;
        rb = 1'b0;
        if (b.action) begin
            clear_clock_state();
            return;
        end
        if (!base_loaded) begin
            if (!seen_first) begin
                seen_first = 1'b1;
                r.verdict = vptg_pkg::VERDICT_PLAY;
                r.flush_cache = 1'b1;
                verdict_q.push_back(r);
                return;
            end
            load_base(b.frame_pts, b.now_ms);
            rb = 1'b1;
        end
        if (!key_synced && b.is_keyframe) begin
            load_base(b.frame_pts, b.now_ms);
            key_synced = 1'b1;
            rb = 1'b1;
        end
        pts_l = longint'(b.frame_pts);
        base_l = longint'(base_pts_q);
        delta = pts_l - base_l;
        if (scale_on) begin
            divisor = longint'(rate_reg);
            if (divisor == 0) begin
                divisor = 1;
            end
            rel = (delta * 1000) / divisor;
        end else begin
            rel = delta;
        end
        elapsed = b.now_ms - start_tick_q;
        elapsed_l = longint'(elapsed);
        cache_l = longint'(cache_reg);
        cap_l = longint'(lead_cap);
        lead = rel + cache_l - elapsed_l;
        if (lead < 0) begin
            r.verdict = vptg_pkg::VERDICT_LATE;
            late_run++;
            if (late_run > vptg_pkg::STREAK_LIMIT) begin
                load_base(b.frame_pts, b.now_ms);
                rb = 1'b1;
                late_run = 0;
            end
        end else if (lead <= cap_l) begin
            r.verdict = vptg_pkg::VERDICT_PLAY;
            if (b.is_keyframe) begin
                load_base(b.frame_pts, b.now_ms);
                rb = 1'b1;
            end
        end else begin
            r.verdict = vptg_pkg::VERDICT_WAIT;
            early_run++;
            if (early_run > vptg_pkg::STREAK_LIMIT) begin
                load_base(b.frame_pts, b.now_ms);
                rb = 1'b1;
                early_run = 0;
            end
        end
        if (lead > 64'sd2147483647) begin
            lead = 64'sd2147483647;
        end else if (lead < -64'sd2147483648) begin
            lead = -64'sd2147483648;
        end
        r.flush_cache = 1'b0;
        r.rebased = rb;
        r.lead_ms = lead[31:0];
        verdict_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        vptg_pkg::out_beat_t want;
        if (!aresetn) begin
            scale_on = 1'b1;
            rate_reg = vptg_pkg::RATE_RESET;
            cache_reg = vptg_pkg::CACHE_RESET;
            lead_cap = vptg_pkg::LEAD_RESET;
            clear_clock_state();
            verdict_q.delete();
        end else begin
            if (cfg_we) begin
                case (vptg_pkg::cfg_idx_t'(cfg_addr))
                    vptg_pkg::CFG_SCALE_TO_MS:   scale_on = cfg_wdata[0];
                    vptg_pkg::CFG_CLOCK_RATE:    rate_reg = cfg_wdata[vptg_pkg::RATE_W-1:0];
                    vptg_pkg::CFG_CACHE_TIME_MS: cache_reg = cfg_wdata[vptg_pkg::MS_W-1:0];
                    vptg_pkg::CFG_MAX_LEAD_MS:   lead_cap = cfg_wdata[vptg_pkg::MS_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected, lead %0d",
                                              m_data.lead_ms));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.verdict !== want.verdict
                            || m_data.flush_cache !== want.flush_cache
                            || m_data.rebased !== want.rebased
                            || m_data.lead_ms !== want.lead_ms) begin
                        report_mismatch($sformatf(
                            "got v%0d f%0b r%0b lead %0d, expected v%0d f%0b r%0b lead %0d",
                            m_data.verdict, m_data.flush_cache, m_data.rebased,
                            m_data.lead_ms, want.verdict, want.flush_cache,
                            want.rebased, want.lead_ms));
                    end
                end
            end
            if (s_valid && s_ready) begin
                judge_frame(s_data);
            end
            if (end_of_run && !ended) begin
                ended = 1;
                if (verdict_q.size() != 0) begin
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              verdict_q.size()));
                end
            end
        end
        fail_count <= fail_tally;
        pending <= verdict_q.size();
    end

endmodule

// ===== bench/tb_video_playout_timing_gate_unit.sv =====
// Testbench top for the video playout timing gate: clock, reset, register writes,
// frame beat stimulus with random gaps and back-pressure, watchdog and verdict.
// Depends on vptg_pkg, the block itself and playout_verdict_checker.
module tb_video_playout_timing_gate_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASE_ITEMS    = 250;
    localparam int PH_N           = 8;

    localparam int PH_SCALE [PH_N] = '{1, 0, 1, 1, 1, 0, 1, 1};
    localparam int PH_RATE  [PH_N] = '{90000, 1, 1000000, 1, 0, 48000, 48000, 90000};
    localparam int PH_CACHE [PH_N] = '{100, 0, 10000, 10000, 50, 200, 40, 100};
    localparam int PH_LEAD  [PH_N] = '{100, 0, 10000, 0, 200, 50, 80, 100};

    logic                           aclk;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [vptg_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [vptg_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    vptg_pkg::in_beat_t             s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    vptg_pkg::out_beat_t            m_data;
    logic                           end_of_run = 1'b0;
    int                             fail_count;
    int                             pending;

    bit                             gaps_on = 1'b1;
    int                             idle_cycles = 0;
    int                             cur_scale = 1;
    int                             cur_rate = 90000;
    int                             cur_cache = 100;
    int                             cur_maxlead = 100;
    logic [vptg_pkg::PTS_W-1:0]     cur_pts;
    logic [vptg_pkg::TICK_W-1:0]    cur_now;

    video_playout_timing_gate_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    playout_verdict_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .end_of_run (end_of_run),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_beat(input vptg_pkg::in_beat_t b);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_event(input logic act, input logic [vptg_pkg::PTS_W-1:0] pts,
                              input logic [vptg_pkg::TICK_W-1:0] now, input logic key);
        vptg_pkg::in_beat_t b;
        b.action = act;
        b.frame_pts = pts;
        b.now_ms = now;
        b.is_keyframe = key;
        send_beat(b);
    endtask

    // Holds the sender off until every result is out, then lets the block go quiet.
    task automatic settle_block();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_setting(input int scale, input int rate, input int cache,
                                 input int maxlead);
        cfg_we <= 1'b1;
        cfg_addr <= vptg_pkg::CFG_SCALE_TO_MS;
        cfg_wdata <= vptg_pkg::CFG_W'(scale);
        @(posedge aclk);
        cfg_addr <= vptg_pkg::CFG_CLOCK_RATE;
        cfg_wdata <= vptg_pkg::CFG_W'(rate);
        @(posedge aclk);
        cfg_addr <= vptg_pkg::CFG_CACHE_TIME_MS;
        cfg_wdata <= vptg_pkg::CFG_W'(cache);
        @(posedge aclk);
        cfg_addr <= vptg_pkg::CFG_MAX_LEAD_MS;
        cfg_wdata <= vptg_pkg::CFG_W'(maxlead);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_scale = scale;
        cur_rate = rate;
        cur_cache = cache;
        cur_maxlead = maxlead;
    endtask

    // Mostly a steady stream of frames with jitter, late and early jumps, plus
    // occasional clock resets and frames with random contents.
    task automatic play_stream(input int count);
        vptg_pkg::in_beat_t b;
        int                 fi;
        int                 r;
        longint             step;
        cur_pts = $urandom();
        cur_now = $urandom();
        if ($urandom_range(0, 2) == 0) begin
            cur_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
        for (int i = 0; i < count; i++) begin
            fi = $urandom_range(10, 40);
            if (cur_scale != 0) begin
                step = (longint'(cur_rate) * fi) / 1000;
            end else begin
                step = fi;
            end
            r = $urandom_range(0, 99);
            b = '0;
            if (r < 2) begin
                b.action = 1'b1;
                b.frame_pts = $urandom();
                b.now_ms = $urandom();
                b.is_keyframe = 1'($urandom_range(0, 1));
            end else if (r < 10) begin
                b.frame_pts = $urandom();
                b.now_ms = $urandom();
                b.is_keyframe = 1'($urandom_range(0, 1));
            end else begin
                cur_pts = cur_pts + step[31:0];
                cur_now = cur_now + fi + $urandom_range(0, 6) - 3;
                if (r < 14) begin
                    cur_now = cur_now + $urandom_range(0, 2 * (cur_cache + cur_maxlead) + 400);
                end else if (r < 18) begin
                    cur_pts = cur_pts + step[31:0] * $urandom_range(2, 40);
                end
                b.frame_pts = cur_pts;
                b.now_ms = cur_now;
                b.is_keyframe = ($urandom_range(0, 14) == 0);
            end
            send_beat(b);
            if (i == count / 3) begin
                settle_block();
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset register values.
        send_event(1'b0, 32'd0, 32'd0, 1'b0);
        send_event(1'b0, 32'd9000, 32'd100, 1'b0);
        send_event(1'b0, 32'd18000, 32'd200, 1'b1);
        send_event(1'b0, 32'd21000, 32'd233, 1'b1);
        for (int k = 1; k <= 7; k++) begin
            send_event(1'b0, 32'd21000 + 3000 * k, 32'd2000 + 33 * k, 1'b0);
        end
        for (int k = 1; k <= 7; k++) begin
            send_event(1'b0, 32'd42000 + 90000 * k, 32'd2231 + 33 * k, 1'b0);
        end
        send_event(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(1'b0, 32'd0, 32'd0, 1'b0);
        send_event(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
        send_event(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
        send_event(1'b0, 32'hFFFF_FFFF, 32'h0000_0010, 1'b0);
        send_event(1'b0, 32'd0, 32'd20, 1'b0);
        settle_block();

        for (int p = 0; p < PH_N; p++) begin
            apply_setting(PH_SCALE[p], PH_RATE[p], PH_CACHE[p], PH_LEAD[p]);
            if (p == PH_N - 1) begin
                gaps_on = 1'b0;
            end
            play_stream(PHASE_ITEMS);
            settle_block();
        end

        end_of_run <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== video_playout_timing_gate_unit.f =====
+incdir+src
src/vptg_pkg.sv
src/vptg_div.sv
src/video_playout_timing_gate_unit.sv
src/vptg_checker.sv
bench/playout_verdict_checker.sv
bench/tb_video_playout_timing_gate_unit.sv
